### hw/rtl/http_body_framer_macros.svh
// ---------------------------------------------------------------------------
// http_body_framer_macros
// Assertion helpers shared by the framer RTL. Clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef HTTP_BODY_FRAMER_MACROS_SVH
`define HTTP_BODY_FRAMER_MACROS_SVH

// same-cycle implication
`define HBF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hbf_pkg.sv
// ---------------------------------------------------------------------------
// hbf_pkg
// Types, codes and helpers for the HTTP body framer.
// ---------------------------------------------------------------------------
package hbf_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;
    localparam int CL_W              = 32;

    // configuration register indexes
    localparam logic CFG_BODY_MODE      = 1'b0;
    localparam logic CFG_CONTENT_LENGTH = 1'b1;

    // body modes (code 3 behaves as close mode)
    localparam logic [1:0] MODE_CHUNKED = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_CLOSE   = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [1:0] SKIP_BYTES = 2'd2;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_SIZE  = 3'd1,
        PH_DATA  = 3'd2,
        PH_SKIP  = 3'd3,
        PH_TRAIL = 3'd4,
        PH_LEN   = 3'd5,
        PH_CLOSE = 3'd6
    } phase_t;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] res;
        res = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            res = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            res = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            res = {1'b1, 4'(b - 8'h57)};
        end
        return res;
    endfunction

endpackage

### hw/rtl/http_body_framer.sv
// A word accepted on s_axis is held in the input register, then moves to the result
//   register, from which m_axis takes it; a stall on m_axis holds it in place.
// Throughput: one word per cycle while m_axis is not stalled; the phase/counter
//   update between the two registers is the only loop.
// Reset: rst_n clears phase, counters, config and both valid flags at once;
//   no clearing pass, the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
// http_body_framer
// Byte-serial HTTP/1.1 body framer: chunked, fixed length and close modes.
// ---------------------------------------------------------------------------
`include "http_body_framer_macros.svh"

module http_body_framer #(
    parameter int SIZE_BITS = hbf_pkg::SIZE_BITS_DEFAULT   // 16 .. 40
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,      // 0 body_mode, 1 content_length
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] end_of_input
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] body_byte
    output logic [1:0]  m_axis_tuser,   // [0] body_valid, [1] size_error
    output logic        m_axis_tlast    // message_done
);
    import hbf_pkg::*;

    // remaining holds either a chunk size (SIZE_BITS) or content_length (32)
    localparam int REM_W = (SIZE_BITS > CL_W) ? SIZE_BITS : CL_W;
    localparam logic [REM_W-1:0] SIZE_MASK = REM_W'({SIZE_BITS{1'b1}});

    // ---------------- configuration ----------------
    logic [1:0]      mode_reg;
    logic [CL_W-1:0] clen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CHUNKED;
            clen_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BODY_MODE:      mode_reg <= cfg_data[1:0];
                CFG_CONTENT_LENGTH: clen_reg <= cfg_data[CL_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- handshake / pipeline control ----------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bvalid_reg;
    logic       out_done_reg;
    logic       out_err_reg;

    logic out_free;   // result register can take a word this cycle
    logic step;       // word in the input register is processed this cycle

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser;
        end
    end

    // ---------------- framing state ----------------
    phase_t           phase_reg,     phase_next;
    logic [REM_W-1:0] remaining_reg, remaining_next;
    logic             digits_ended_reg, digits_ended_next;
    logic             saw_cr_reg,    saw_cr_next;
    logic [1:0]       skip_count_reg, skip_count_next;

    // state as seen after a message start is taken into account
    phase_t           ph_eff;
    logic [REM_W-1:0] rem_eff;
    logic             de_eff;
    logic             cr_eff;
    logic             start_done;   // zero-length message completes here

    always_comb
    begin
        ph_eff     = phase_reg;
        rem_eff    = remaining_reg;
        de_eff     = digits_ended_reg;
        cr_eff     = saw_cr_reg;
        start_done = 1'b0;
        if (phase_reg == PH_START)
        begin
            case (mode_reg)
                MODE_CHUNKED:
                begin
                    ph_eff  = PH_SIZE;
                    rem_eff = '0;
                    de_eff  = 1'b0;
                    cr_eff  = 1'b0;
                end
                MODE_LENGTH:
                begin
                    if (clen_reg == '0)
                    begin
                        start_done = 1'b1;
                    end
                    else
                    begin
                        ph_eff  = PH_LEN;
                        rem_eff = REM_W'(clen_reg);
                    end
                end
                default:
                begin
                    ph_eff = PH_CLOSE;
                end
            endcase
        end
    end

    // shared datapath terms
    logic [4:0]       hex;
    logic             is_hex;
    logic             line_end;
    logic             size_ovf;
    logic [REM_W-1:0] rem_dec;
    logic [REM_W-1:0] rem_shift;
    logic [1:0]       skip_dec;

    assign hex       = hex_decode(in_byte_reg);
    assign is_hex    = hex[4];
    assign line_end  = cr_eff && (in_byte_reg == CHAR_LF);
    // another digit would push the size past SIZE_BITS
    assign size_ovf  = (rem_eff >> (SIZE_BITS - 4)) != '0;
    assign rem_dec   = (rem_eff - REM_W'(1)) & SIZE_MASK;
    assign rem_shift = ((rem_eff << 4) | REM_W'(hex[3:0])) & SIZE_MASK;
    assign skip_dec  = (skip_count_reg != 2'd0) ? skip_count_reg - 2'd1 : 2'd0;

    // next state
    always_comb
    begin
        phase_next        = ph_eff;
        remaining_next    = rem_eff;
        digits_ended_next = de_eff;
        saw_cr_next       = cr_eff;
        skip_count_next   = skip_count_reg;
        if (in_eoi_reg)
        begin
            phase_next        = PH_START;
            remaining_next    = '0;
            digits_ended_next = 1'b0;
            saw_cr_next       = 1'b0;
            skip_count_next   = 2'd0;
        end
        else
        begin
            case (ph_eff)
                PH_SIZE:
                begin
                    if (line_end)
                    begin
                        saw_cr_next = 1'b0;
                        if (rem_eff == '0)
                        begin
                            phase_next      = PH_TRAIL;
                            skip_count_next = SKIP_BYTES;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        saw_cr_next = (in_byte_reg == CHAR_CR);
                        if (!de_eff)
                        begin
                            if (!is_hex)
                            begin
                                digits_ended_next = 1'b1;
                            end
                            else if (size_ovf)
                            begin
                                phase_next        = PH_START;
                                remaining_next    = '0;
                                digits_ended_next = 1'b0;
                                saw_cr_next       = 1'b0;
                            end
                            else
                            begin
                                remaining_next = rem_shift;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next      = PH_SKIP;
                        skip_count_next = SKIP_BYTES;
                    end
                end
                PH_SKIP:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 2'd0)
                    begin
                        phase_next        = PH_SIZE;
                        remaining_next    = '0;
                        digits_ended_next = 1'b0;
                        saw_cr_next       = 1'b0;
                    end
                end
                PH_TRAIL:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 2'd0)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_LEN:
                begin
                    remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    // start with empty message, close mode: nothing changes
                end
            endcase
        end
    end

    // result flags
    logic body_valid_c;
    logic done_c;
    logic err_c;

    always_comb
    begin
        body_valid_c = 1'b0;
        done_c       = 1'b0;
        err_c        = 1'b0;
        if (in_eoi_reg)
        begin
            done_c = (phase_reg == PH_CLOSE);
        end
        else
        begin
            done_c = start_done;
            case (ph_eff)
                PH_SIZE:  err_c = !line_end && !de_eff && is_hex && size_ovf;
                PH_DATA:  body_valid_c = 1'b1;
                PH_TRAIL: done_c = (skip_dec == 2'd0);
                PH_LEN:
                begin
                    body_valid_c = 1'b1;
                    done_c       = (rem_dec == '0);
                end
                PH_CLOSE: body_valid_c = 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            remaining_reg    <= '0;
            digits_ended_reg <= 1'b0;
            saw_cr_reg       <= 1'b0;
            skip_count_reg   <= 2'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            digits_ended_reg <= digits_ended_next;
            saw_cr_reg       <= saw_cr_next;
            skip_count_reg   <= skip_count_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg   <= body_valid_c ? in_byte_reg : 8'd0;
            out_bvalid_reg <= body_valid_c;
            out_done_reg   <= done_c;
            out_err_reg    <= err_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_err_reg, out_bvalid_reg};
    assign m_axis_tlast  = out_done_reg;

    // ---------------- assertions ----------------
    `HBF_ASSERT_IMPL(a_err_alone, out_valid_reg && out_err_reg,
        !out_bvalid_reg && !out_done_reg, "size error with payload or done")
    `HBF_ASSERT_IMPL(a_count_live, (phase_reg == PH_DATA) || (phase_reg == PH_LEN),
        remaining_reg != '0, "data phase with zero byte count")
    `HBF_ASSERT_IMPL(a_skip_phase, skip_count_reg != 2'd0,
        (phase_reg == PH_SKIP) || (phase_reg == PH_TRAIL), "skip count outside skip phase")
    `HBF_ASSERT_NEXT(a_eoi_start, step && in_eoi_reg,
        phase_reg == PH_START, "end of input did not return to start")
    `HBF_ASSERT_NEXT(a_err_abort, step && err_c,
        (phase_reg == PH_START) && (remaining_reg == '0), "size error did not abort")

endmodule

### sim/http_body_framer_tb.sv
// ---------------------------------------------------------------------------
// http_body_framer_tb
// Self-checking bench for the HTTP body framer. Byte words go in on s_axis,
// a scoreboard model predicts one result word per input word, and every
// m_axis word is compared field by field with the oldest prediction. Runs a
// few directed cases, then about 1300 words of random message traffic in all
// modes, with random bubbles on s_axis and random back-pressure on m_axis.
// ---------------------------------------------------------------------------
module http_body_framer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hbf_pkg::*;

    localparam int SB = SIZE_BITS_DEFAULT;

    // spare mode code, must behave like close mode
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // one predicted m_axis word
    typedef struct packed {
        logic [7:0] body;
        logic       valid;
        logic       done;
        logic       err;
    } body_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0; // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] body_byte
    logic [1:0]  m_axis_tuser;        // [0] body_valid, [1] size_error
    logic        m_axis_tlast;        // message_done

    http_body_framer #(
        .SIZE_BITS(SB)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // -----------------------------------------------------------------------
    // Scoreboard model state (mirrors the framer after reset)
    // -----------------------------------------------------------------------
    logic [1:0]    mode_reg = MODE_CHUNKED;
    logic [31:0]   clen_reg = '0;
    phase_t        fr_phase = PH_START;
    logic [SB-1:0] fr_left = '0;        // size accumulator / bytes left
    logic          fr_digits_ended = 1'b0;
    logic          fr_saw_cr = 1'b0;
    logic [1:0]    fr_skip = '0;

    body_word_t    pending_body[$];     // predictions not yet seen on m_axis
    body_word_t    oldest_word;

    // when set, neither side inserts bubbles
    bit            steady = 1'b0;

    int unsigned   sent_words = 0;
    int unsigned   cfg_writes = 0;
    int unsigned   payload_seen = 0;
    int unsigned   msgs_seen = 0;
    int unsigned   size_errs_seen = 0;
    int unsigned   mismatches = 0;

    // extension text pool: no LF, so an embedded CR never ends the line
    logic [7:0] ext_pool [8] = '{8'h3B, 8'h20, 8'h3D, 8'h78, 8'h41, 8'h66, 8'h39, 8'h0D};

    // Advance the framer model by one input word and return its result word.
    function automatic body_word_t frame_byte(input logic [7:0] b, input logic eoi);
        body_word_t r;
        logic       is_hex;
        logic [3:0] nib;
        r = '0;
        is_hex = 1'b1;
        nib = 4'd0;
        // '0'..'9' carry the value in the low nibble; 'A'..'F', 'a'..'f' are +9
        if (b >= 8'h30 && b <= 8'h39)
            nib = b[3:0];
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            nib = b[3:0] + 4'd9;
        else
            is_hex = 1'b0;

        if (eoi)
        begin
            // connection closed: only a close-mode body counts as complete
            r.done = (fr_phase == PH_CLOSE);
            fr_phase = PH_START;
            fr_left = '0;
            fr_skip = '0;
            fr_saw_cr = 1'b0;
            fr_digits_ended = 1'b0;
        end
        else
        begin
            // mode is latched only when a new message starts
            if (fr_phase == PH_START)
            begin
                if (mode_reg == MODE_CHUNKED)
                begin
                    fr_phase = PH_SIZE;
                    fr_left = '0;
                    fr_digits_ended = 1'b0;
                    fr_saw_cr = 1'b0;
                end
                else if (mode_reg == MODE_LENGTH)
                begin
                    if (clen_reg == 0)
                        r.done = 1'b1;   // empty body, byte dropped
                    else
                    begin
                        fr_left = clen_reg;
                        fr_phase = PH_LEN;
                    end
                end
                else
                    fr_phase = PH_CLOSE;
            end

            case (fr_phase)
                PH_SIZE:
                begin
                    if (fr_saw_cr && b == CHAR_LF)
                    begin
                        fr_saw_cr = 1'b0;
                        if (fr_left == 0)
                        begin
                            fr_phase = PH_TRAIL;
                            fr_skip = SKIP_BYTES;
                        end
                        else
                            fr_phase = PH_DATA;
                    end
                    else
                    begin
                        fr_saw_cr = (b == CHAR_CR);
                        if (!fr_digits_ended)
                        begin
                            if (!is_hex)
                                fr_digits_ended = 1'b1;
                            else if (fr_left[SB-1 -: 4] != 0)
                            begin
                                // another digit would not fit: abort message
                                r.err = 1'b1;
                                fr_phase = PH_START;
                                fr_left = '0;
                                fr_digits_ended = 1'b0;
                                fr_saw_cr = 1'b0;
                            end
                            else
                                fr_left = {fr_left[SB-5:0], nib};
                        end
                    end
                end
                PH_DATA:
                begin
                    r.valid = 1'b1;
                    fr_left = fr_left - SB'(1);
                    if (fr_left == 0)
                    begin
                        fr_phase = PH_SKIP;
                        fr_skip = SKIP_BYTES;
                    end
                end
                PH_SKIP:
                begin
                    if (fr_skip != 0)
                        fr_skip = fr_skip - 2'd1;
                    if (fr_skip == 0)
                    begin
                        fr_phase = PH_SIZE;
                        fr_left = '0;
                        fr_digits_ended = 1'b0;
                        fr_saw_cr = 1'b0;
                    end
                end
                PH_TRAIL:
                begin
                    if (fr_skip != 0)
                        fr_skip = fr_skip - 2'd1;
                    if (fr_skip == 0)
                    begin
                        fr_phase = PH_START;
                        r.done = 1'b1;
                    end
                end
                PH_LEN:
                begin
                    r.valid = 1'b1;
                    fr_left = fr_left - SB'(1);
                    if (fr_left == 0)
                    begin
                        fr_phase = PH_START;
                        r.done = 1'b1;
                    end
                end
                PH_CLOSE:
                    r.valid = 1'b1;
                default: ;
            endcase
        end
        r.body = r.valid ? b : 8'h00;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------

    // Send one word on s_axis with random bubbles; predict it on acceptance.
    // tvalid is left high afterwards, so back-to-back words need no toggling.
    task automatic send_word(input logic [7:0] b, input logic eoi);
        while (!steady && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'($urandom_range(255));
            s_axis_tuser <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= eoi;
        do @(posedge clk); while (!s_axis_tready);
        pending_body.push_back(frame_byte(b, eoi));
        sent_words++;
    endtask

    // Stop sending and wait for every predicted word to come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_body.size() != 0);
        repeat (2) @(posedge clk);   // two-stage pipe, nothing left inside
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BODY_MODE)
            mode_reg = val[1:0];
        else
            clen_reg = val;
        cfg_writes++;
    endtask

    // mode write, sometimes with junk in the unused upper bits
    task automatic set_mode(input logic [1:0] m);
        logic [31:0] val;
        val = {30'd0, m};
        if ($urandom_range(3) == 0)
            val = ($urandom & 32'hFFFF_FFFC) | val;
        write_reg(CFG_BODY_MODE, val);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // mostly no padding, sometimes long runs of leading zeros
    function automatic int unsigned random_pad();
        return ($urandom_range(7) == 0) ? $urandom_range(1, 12) : 0;
    endfunction

    // Chunk-size line: zeros, hex digits (mixed case), optional extension, CR LF.
    // size 0 with no padding gives a line without any digits.
    task automatic send_size_line(input logic [31:0] size, input int unsigned lead,
                                  input bit ext);
        logic [3:0] nib;
        bit         started;
        started = 1'b0;
        repeat (lead) send_word(8'h30, 1'b0);
        for (int i = 7; i >= 0; i--)
        begin
            nib = size[i*4 +: 4];
            if (nib != 0 || started)
            begin
                started = 1'b1;
                send_word(hex_char(nib, 1'($urandom_range(1))), 1'b0);
            end
        end
        if (ext)
        begin
            // ';' ends the digits, hex letters after it must be ignored
            send_word(8'h3B, 1'b0);
            repeat ($urandom_range(1, 5))
                send_word(ext_pool[3'($urandom_range(7))], 1'b0);
        end
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
    endtask

    // the two bytes after chunk data are skipped unchecked
    task automatic send_crlf_or_junk();
        if ($urandom_range(3) != 0)
        begin
            send_word(CHAR_CR, 1'b0);
            send_word(CHAR_LF, 1'b0);
        end
        else
            repeat (2) send_word(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_chunk(input int unsigned len);
        send_size_line(len, random_pad(), $urandom_range(3) == 0);
        repeat (len) send_word(8'($urandom_range(255)), 1'b0);
        send_crlf_or_junk();
    endtask

    // -----------------------------------------------------------------------
    // Message generators for the random phase
    // -----------------------------------------------------------------------
    task automatic send_chunked_message();
        int unsigned variant;
        int unsigned len;
        if (mode_reg != MODE_CHUNKED || $urandom_range(7) == 0)
            set_mode(MODE_CHUNKED);
        variant = $urandom_range(19);
        if (variant == 0)
        begin
            // nine significant digits: the ninth overflows, then a fresh message
            send_word(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))), 1'b0);
            repeat (8)
                send_word(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
        end
        else if (variant == 1)
        begin
            // largest size that fits, cut off by connection close
            send_size_line(32'hFFFF_FFFF, random_pad(), 1'b0);
            repeat ($urandom_range(5)) send_word(8'($urandom_range(255)), 1'b0);
            send_word(8'($urandom_range(255)), 1'b1);
            return;
        end
        else if (variant == 2)
        begin
            // chunk dropped partway through its data
            len = $urandom_range(2, 12);
            send_size_line(len, random_pad(), 1'($urandom_range(1)));
            repeat ($urandom_range(len - 1)) send_word(8'($urandom_range(255)), 1'b0);
            send_word(8'($urandom_range(255)), 1'b1);
            return;
        end
        repeat ($urandom_range(3))
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_chunk(len);
        end
        // last chunk: "0" or no digits at all
        send_size_line(0, ($urandom_range(4) == 0) ? 0 : 1 + random_pad(),
                       $urandom_range(3) == 0);
        send_crlf_or_junk();
    endtask

    task automatic send_length_message();
        logic [31:0] len;
        int unsigned cut;
        case ($urandom_range(9))
            0:       len = 32'd0;
            1:       len = $urandom;
            default: len = $urandom_range(1, 24);
        endcase
        if (clen_reg != len || $urandom_range(3) == 0)
            write_reg(CFG_CONTENT_LENGTH, len);
        if (mode_reg != MODE_LENGTH)
            set_mode(MODE_LENGTH);
        if (len == 0)
            send_word(8'($urandom_range(255)), 1'b0);
        else
        begin
            if (len > 40)
                cut = $urandom_range(6);
            else if ($urandom_range(7) == 0)
                cut = $urandom_range(len - 1);
            else
                cut = len;
            repeat (cut) send_word(8'($urandom_range(255)), 1'b0);
            if (cut != len)
                send_word(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic send_close_message();
        if ((mode_reg != MODE_CLOSE && mode_reg != MODE_SPARE) || $urandom_range(3) == 0)
            set_mode(($urandom_range(2) == 0) ? MODE_SPARE : MODE_CLOSE);
        repeat ($urandom_range(20)) send_word(8'($urandom_range(255)), 1'b0);
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Eight F digits fit exactly, the next digit raises size_error.
    task automatic test_size_overflow();
        set_mode(MODE_CHUNKED);
        for (int i = 0; i < 8; i++)
            send_word(hex_char(4'hF, i[0]), 1'b0);
        send_word(hex_char(4'h0, 1'b0), 1'b0);
    endtask

    // Zero length, one byte, and the largest length cut short by close.
    task automatic test_length_mode();
        set_mode(MODE_LENGTH);
        write_reg(CFG_CONTENT_LENGTH, 32'd0);
        send_word(8'h41, 1'b0);
        write_reg(CFG_CONTENT_LENGTH, 32'd1);
        send_word(8'hFF, 1'b0);
        write_reg(CFG_CONTENT_LENGTH, 32'hFFFF_FFFF);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // Close mode and the spare mode code; close while idle raises nothing.
    task automatic test_close_mode();
        set_mode(MODE_CLOSE);
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_word(8'hFF, 1'b1);
        write_reg(CFG_BODY_MODE, 32'hFFFF_FFFF);   // upper bits ignored, code 3
        send_word(8'h00, 1'b0);
        send_word(8'h5A, 1'b1);
        send_word(8'hA5, 1'b1);
    endtask

    // A chunked message keeps its mode when the register changes under it.
    task automatic test_mode_switch();
        set_mode(MODE_CHUNKED);
        write_reg(CFG_CONTENT_LENGTH, 32'd1);
        send_size_line(32'd1, 0, 1'b0);
        send_word(8'h00, 1'b0);
        wait_results_drained();
        set_mode(MODE_LENGTH);
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_size_line(32'd0, 0, 1'b0);   // line without digits ends the body
        send_word(8'h7E, 1'b0);
        send_word(8'h81, 1'b0);
        send_word(8'hC3, 1'b0);           // new message, now length mode
    endtask

    task automatic test_random_traffic();
        int unsigned first;
        int unsigned kind;
        first = sent_words;
        while (sent_words < first + 1300)
        begin
            // one long stretch with no bubbles on either side
            steady = (sent_words >= first + 450 && sent_words < first + 700);
            // if noise left the framer mid-way, mostly send a close so the next message starts idle
            if (fr_phase != PH_START && $urandom_range(3) != 0)
                send_word(8'($urandom_range(255)), 1'b1);
            kind = $urandom_range(99);
            if (kind < 45)
                send_chunked_message();
            else if (kind < 70)
                send_length_message();
            else if (kind < 92)
                send_close_message();
            else
            begin
                // noise: a few loose bytes and closes in whatever mode is set
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom_range(255)), $urandom_range(2) == 0);
            end
            // sender holds off until the pipe is empty
            if ($urandom_range(9) == 0)
                wait_results_drained();
        end
        steady = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // -----------------------------------------------------------------------
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 33);

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_body.size() == 0)
                report_mismatch("word with nothing expected", 32'(m_axis_tdata), 32'd0);
            else
            begin
                oldest_word = pending_body.pop_front();
                if (m_axis_tdata !== oldest_word.body)
                    report_mismatch("body_byte", 32'(m_axis_tdata), 32'(oldest_word.body));
                if (m_axis_tuser[0] !== oldest_word.valid)
                    report_mismatch("body_valid", 32'(m_axis_tuser[0]),
                                    32'(oldest_word.valid));
                if (m_axis_tuser[1] !== oldest_word.err)
                    report_mismatch("size_error", 32'(m_axis_tuser[1]),
                                    32'(oldest_word.err));
                if (m_axis_tlast !== oldest_word.done)
                    report_mismatch("message_done", 32'(m_axis_tlast),
                                    32'(oldest_word.done));
                if (oldest_word.valid)
                    payload_seen++;
                if (oldest_word.done)
                    msgs_seen++;
                if (oldest_word.err)
                    size_errs_seen++;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_overflow();
        test_length_mode();
        test_close_mode();
        test_mode_switch();
        test_random_traffic();

        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("sent %0d words, %0d register writes; saw %0d payload bytes,",
                 sent_words, cfg_writes, payload_seen);
        $display("%0d completed bodies and %0d size errors, %0d mismatches",
                 msgs_seen, size_errs_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d words outstanding", pending_body.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
